FILE: rtl/mandelbrot_pixel_colorer_top_assert.svh
// Assertion macros for the Mandelbrot pixel colorer.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef MANDELBROT_PIXEL_COLORER_TOP_ASSERT_SVH
`define MANDELBROT_PIXEL_COLORER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define MPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define MPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define MPC_ASSERT(lbl, prop, msg)

`define MPC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/mpc_pkg.sv
`timescale 1ns / 1ps

package mpc_pkg;

  localparam int FIX_W     = 16;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 6;
  localparam int COLOR_W   = 5;
  localparam int ITER_OUT_W = 7;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;

  localparam logic [FIX_W-1:0] ORIGIN_X_RST = 16'hFE00;  // -2.0
  localparam logic [FIX_W-1:0] ORIGIN_Y_RST = 16'h0110;  // 1.0625
  localparam logic [FIX_W-1:0] STEP_RST     = 16'h0009;

  localparam logic [FIX_W-1:0] FIX_ONE      = 16'h0100;
  localparam logic [FIX_W-1:0] ESCAPE_LIMIT = 16'h0400;  // 4.0

  localparam int SKIP_INDEX = 10;
  localparam int TOP_INDEX  = 25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MCOL,
    ST_MROW,
    ST_FIRST,
    ST_MXX,
    ST_MYY,
    ST_MXY,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,    // capture pixel, clear counter
    OP_MCOL,    // step * col
    OP_MROW,    // step * row, form cx
    OP_CY_XX,   // form cy, square x
    OP_ZY_XX,   // update zy, square x
    OP_YY,      // square y
    OP_XY       // cross product, update zx, escape test
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic escape;
    logic last;
  } dp_status_t;

endpackage

FILE: rtl/mpc_ctrl.sv
`timescale 1ns / 1ps

module mpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mpc_pkg::dp_status_t status,
  output mpc_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import mpc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MCOL;
      ST_MCOL:  state_nxt = ST_MROW;
      ST_MROW:  state_nxt = ST_FIRST;
      ST_FIRST: state_nxt = ST_MYY;
      ST_MXX:   state_nxt = ST_MYY;
      ST_MYY:   state_nxt = ST_MXY;
      ST_MXY: begin
        if (status.escape || status.last) state_nxt = ST_DONE;
        else state_nxt = ST_MXX;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    busy   = 1'b1;
    done   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = OP_LOAD;
      end
      ST_MCOL:  cmd.op = OP_MCOL;
      ST_MROW:  cmd.op = OP_MROW;
      ST_FIRST: cmd.op = OP_CY_XX;
      ST_MXX:   cmd.op = OP_ZY_XX;
      ST_MYY:   cmd.op = OP_YY;
      ST_MXY:   cmd.op = OP_XY;
      ST_DONE:  done = 1'b1;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/mpc_datapath.sv
`timescale 1ns / 1ps

module mpc_datapath #(
  parameter int MAX_ITER = 100
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mpc_pkg::dp_cmd_t                    cmd,
  output mpc_pkg::dp_status_t                 status,
  input  logic                                cfg_we,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mpc_pkg::FIX_W-1:0]           cfg_wdata,
  input  logic [mpc_pkg::COL_W-1:0]           in_col,
  input  logic [mpc_pkg::ROW_W-1:0]           in_row,
  output logic [mpc_pkg::COL_W-1:0]           out_col,
  output logic [mpc_pkg::ROW_W-1:0]           out_row,
  output logic [mpc_pkg::COLOR_W-1:0]         out_color,
  output logic [mpc_pkg::ITER_OUT_W-1:0]      out_iterations
);
  import mpc_pkg::*;

  localparam int ITER_W = $clog2(MAX_ITER + 1);

  logic [FIX_W-1:0]   origin_x_r, origin_y_r, step_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [FIX_W-1:0]   lo_r, cx_r, cy_r, zx_r, zy_r, xx_r, yy_r, xy_r;
  logic [ITER_W-1:0]  iter_r;
  logic [COLOR_W-1:0] color_r;

  logic signed [FIX_W-1:0]   mul_a, mul_b;
  logic signed [2*FIX_W-1:0] mul_p;
  logic [FIX_W-1:0]          fx_p;
  logic [FIX_W-1:0]          norm;
  logic [31:0]               iter_ext;

  function automatic logic [COLOR_W-1:0] color_of(input logic [ITER_W-1:0] i);
    logic [31:0] ie;
    logic [31:0] c;
    ie = 32'(i);
    c  = ie + 32'd1;
    if (c >= 32'(SKIP_INDEX)) c = c + 32'd1;
    if (c > 32'(TOP_INDEX)) c = 32'(TOP_INDEX);
    return c[COLOR_W-1:0];
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= ORIGIN_X_RST;
      origin_y_r <= ORIGIN_Y_RST;
      step_r     <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_wdata;
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        REG_STEP:     step_r     <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Shared signed multiplier; low bits serve the pixel offset, [23:8] the 8.8 product
  always_comb begin
    mul_a = signed'(zx_r);
    mul_b = signed'(zx_r);
    case (cmd.op)
      OP_MCOL: begin
        mul_a = signed'(step_r);
        mul_b = signed'({{(FIX_W-COL_W){1'b0}}, col_r});
      end
      OP_MROW: begin
        mul_a = signed'(step_r);
        mul_b = signed'({{(FIX_W-ROW_W){1'b0}}, row_r});
      end
      OP_YY: begin
        mul_a = signed'(zy_r);
        mul_b = signed'(zy_r);
      end
      OP_XY: begin
        mul_a = signed'(zx_r);
        mul_b = signed'(zy_r);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign fx_p  = mul_p[FIX_W+7:8];

  assign norm          = xx_r + yy_r;
  assign status.escape = $signed(norm) > $signed(ESCAPE_LIMIT);
  assign status.last   = (iter_r == ITER_W'(MAX_ITER - 1));

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        col_r  <= in_col;
        row_r  <= in_row;
        iter_r <= '0;
      end
      OP_MCOL: lo_r <= mul_p[FIX_W-1:0];
      OP_MROW: begin
        lo_r <= mul_p[FIX_W-1:0];
        cx_r <= origin_x_r + lo_r;
        zx_r <= origin_x_r + lo_r;
      end
      OP_CY_XX: begin
        cy_r <= origin_y_r - lo_r;
        zy_r <= origin_y_r - lo_r;
        xx_r <= fx_p;
      end
      OP_ZY_XX: begin
        zy_r <= {xy_r[FIX_W-2:0], 1'b0} + cy_r;
        xx_r <= fx_p;
      end
      OP_YY: yy_r <= fx_p;
      OP_XY: begin
        xy_r    <= fx_p;
        zx_r    <= xx_r - yy_r + cx_r;
        color_r <= status.escape ? color_of(iter_r) : '0;
        if (!status.escape) iter_r <= iter_r + ITER_W'(1);
      end
      default: ;
    endcase
  end

  assign iter_ext       = 32'(iter_r);
  assign out_col        = col_r;
  assign out_row        = row_r;
  assign out_color      = color_r;
  assign out_iterations = iter_ext[ITER_OUT_W-1:0];

endmodule

FILE: rtl/mandelbrot_pixel_colorer_top.sv
`timescale 1ns / 1ps
// Mandelbrot escape-time pixel colorer, signed 8.8 fixed point.
// Input: pulse start with in_col/in_row while busy is low; that edge is the transfer.
// The block forms c = (origin_x + step*col, origin_y - step*row) and iterates
// z = z*z + c starting from z = c for up to MAX_ITER rounds, stopping when |z|^2 > 4.0.
// Output: out_valid is high for exactly one cycle with out_col, out_row,
// out_color and out_iterations; the receiver must take it then, it cannot stall.
// After the accepting edge the block forms step*col, then step*row and cx, then cy
// and x*x, and then runs its rounds until escape or until MAX_ITER rounds are done.
// busy drops the cycle after out_valid; a new pixel is taken only once busy is low.
// Each round makes x*x, y*y and x*y in turn on the single shared 16x16 multiplier,
// which also forms step*col and step*row; the adds and the escape test ride along.
// Configuration: cfg_we with cfg_index (0 origin_x, 1 origin_y, 2 step) and
// cfg_wdata writes a register at once; write only while busy is low.
// Reset (synchronous, rst_n low) returns the controller to idle and loads
// origin_x = -2.0, origin_y = 1.0625, step = 9/256.
`include "mandelbrot_pixel_colorer_top_assert.svh"

module mandelbrot_pixel_colorer_top #(
  parameter int MAX_ITER = 100
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [mpc_pkg::COL_W-1:0]        in_col,
  input  logic [mpc_pkg::ROW_W-1:0]        in_row,
  output logic                             out_valid,
  output logic [mpc_pkg::COL_W-1:0]        out_col,
  output logic [mpc_pkg::ROW_W-1:0]        out_row,
  output logic [mpc_pkg::COLOR_W-1:0]      out_color,
  output logic [mpc_pkg::ITER_OUT_W-1:0]   out_iterations,
  input  logic                             cfg_we,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpc_pkg::FIX_W-1:0]        cfg_wdata
);
  import mpc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: setup, x*x / y*y / x*y rounds, one result cycle
  mpc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  // Registers, shared multiplier, z update, escape test and color mapping
  mpc_datapath #(
    .MAX_ITER (MAX_ITER)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_color      (out_color),
    .out_iterations (out_iterations)
  );

  // A transfer in always starts work
  `MPC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted pixel did not raise busy")
  // Result strobe lasts one cycle and is followed by idle (busy low)
  `MPC_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid && !busy, "result strobe not a single pulse")
  // Palette never yields the skipped index and stays capped
  `MPC_ASSERT(a_color_range,
    !out_valid || ((out_color != COLOR_W'(SKIP_INDEX)) && (out_color <= COLOR_W'(TOP_INDEX))),
    "color outside palette")
  // Color zero means the point ran all rounds
  `MPC_ASSERT(a_no_escape_count,
    !(out_valid && (out_color == '0)) || (out_iterations == ITER_OUT_W'(MAX_ITER)),
    "color zero without full round count")

endmodule
